FILE: rtl/tilt_pid_with_fall_guard_defines.svh
// ----------------------------------------------------------------------------
// tilt pid assertion macros
// shared concurrent assertion forms, clocked on clk_i and held off in reset
// ----------------------------------------------------------------------------
`ifndef TILT_PID_WITH_FALL_GUARD_DEFINES_SVH
`define TILT_PID_WITH_FALL_GUARD_DEFINES_SVH

// property holds at every edge out of reset
`define TPFG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// consequent holds in the cycle after the antecedent
`define TPFG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/tpfg_pkg.sv
// ----------------------------------------------------------------------------
// tilt pid package
// widths, constants, register indexes and controller/datapath types
// ----------------------------------------------------------------------------
package tpfg_pkg;

  localparam int unsigned ANGLE_W    = 16;
  localparam int unsigned RATE_W     = 16;
  localparam int unsigned DT_W       = 20;
  localparam int unsigned GAIN_W     = 20;
  localparam int unsigned LIM_W      = 15;
  localparam int unsigned VEL_W      = 16;
  localparam int unsigned ERR_W      = 17;
  localparam int unsigned EI_W       = 36;
  localparam int unsigned EI_SUM_W   = 38;
  localparam int unsigned MUL_A_W    = 37;
  localparam int unsigned MUL_B_W    = 22;
  localparam int unsigned PROD_W     = 60;
  localparam int unsigned SUM_W      = 61;
  localparam int unsigned LIMF_W     = 47;
  localparam int unsigned CL_W       = 48;
  localparam int unsigned X_W        = 29;
  localparam int unsigned Q_W        = 15;
  localparam int unsigned REM_W      = 31;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 20;

  localparam int unsigned LIM_SHIFT   = 12;
  localparam int unsigned D_SHIFT     = 4;
  localparam int unsigned ROUND_SHIFT = 18;
  localparam int unsigned RECIP_SHIFT = 35;

  // 1e6 scale, reciprocal of 15625 at 2^35, and the rounding half of 4096e6
  localparam logic [MUL_B_W-1:0] MEGA  = 22'd1000000;
  localparam logic [MUL_B_W-1:0] RECIP = 22'd2199023;
  localparam logic [MUL_B_W-1:0] DIV   = 22'd15625;
  localparam logic [CL_W-1:0]    HALF  = 48'd2048000000;
  localparam logic [DT_W-1:0]    DT_MAX = 20'd1000000;
  localparam logic signed [EI_W-1:0] INTEG_LIM = 36'sd20480000000;

  localparam logic [GAIN_W-1:0]        PROP_GAIN_RST  = 20'd38400;
  localparam logic [GAIN_W-1:0]        INTEG_GAIN_RST = 20'd128000;
  localparam logic [GAIN_W-1:0]        DERIV_GAIN_RST = 20'd3840;
  localparam logic signed [ANGLE_W-1:0] TRIM_RST      = 16'sd0;
  localparam logic [LIM_W-1:0]         OUT_LIMIT_RST  = 15'd12800;
  localparam logic [LIM_W-1:0]         FALL_THR_RST   = 15'd2867;
  localparam logic [LIM_W-1:0]         RECOVER_THR_RST = 15'd2007;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN    = 3'd0,
    REG_INTEG_GAIN   = 3'd1,
    REG_DERIV_GAIN   = 3'd2,
    REG_TRIM_ANGLE   = 3'd3,
    REG_OUTPUT_LIMIT = 3'd4,
    REG_FALL_THR     = 3'd5,
    REG_RECOVER_THR  = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [GAIN_W-1:0]         prop_gain;
    logic [GAIN_W-1:0]         integ_gain;
    logic [GAIN_W-1:0]         deriv_gain;
    logic signed [ANGLE_W-1:0] trim_angle;
    logic [LIM_W-1:0]          output_limit;
    logic [LIM_W-1:0]          fall_threshold;
    logic [LIM_W-1:0]          recover_threshold;
  } cfg_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_FALL,
    S_MUL_ERR,
    S_MUL_P,
    S_MUL_RATE,
    S_MUL_D,
    S_MUL_LIM,
    S_MUL_I,
    S_MUL_DT,
    S_SAT,
    S_MUL_I2,
    S_SUM2,
    S_CLAMP,
    S_ABS,
    S_MUL_REC,
    S_MUL_BACK,
    S_FIX,
    S_OUT
  } ctrl_state_e;

  typedef enum logic [4:0] {
    STEP_IDLE,
    STEP_FALL,
    STEP_MUL_ERR,
    STEP_MUL_P,
    STEP_MUL_RATE,
    STEP_MUL_D,
    STEP_MUL_LIM,
    STEP_MUL_I,
    STEP_MUL_DT,
    STEP_SAT,
    STEP_MUL_I2,
    STEP_SUM2,
    STEP_CLAMP,
    STEP_ABS,
    STEP_MUL_REC,
    STEP_MUL_BACK,
    STEP_FIX
  } dp_step_e;

  typedef struct packed {
    dp_step_e step;
    logic     capture;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic skip;
    logic fall_next;
    logic sat;
  } dp_sts_t;

endpackage

FILE: rtl/tpfg_if.sv
// ----------------------------------------------------------------------------
// tilt pid channel interfaces
// sample input, command output and register write channels
// ----------------------------------------------------------------------------
interface tpfg_in_if import tpfg_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic signed [ANGLE_W-1:0] tilt_angle;
  logic signed [RATE_W-1:0]  tilt_rate;
  logic [DT_W-1:0]           step_time_us;

  modport source (output valid, tilt_angle, tilt_rate, step_time_us, input ready);
  modport sink (input valid, tilt_angle, tilt_rate, step_time_us, output ready);
endinterface

interface tpfg_out_if import tpfg_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [VEL_W-1:0] left_velocity;
  logic signed [VEL_W-1:0] right_velocity;
  logic                    is_fallen;
  logic                    was_saturated;

  modport source (output valid, left_velocity, right_velocity, is_fallen, was_saturated,
                  input ready);
  modport sink (input valid, left_velocity, right_velocity, is_fallen, was_saturated,
                output ready);
endinterface

interface tpfg_cfg_if import tpfg_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/tilt_pid_with_fall_guard.sv
// driving runs the pid step and reciprocal rounding, a saturated preview
// skips the second integral pass, fallen runs only the fall check, and a skipped step
// frees the input with no result; up to ten passes use the single shared 37x23
// multiplier, and no new sample is taken until the last result is loaded for output
// reset: asynchronous, active low; configuration registers return to their defaults,
// the block is not fallen, the integral is zero and no result is pending
// ----------------------------------------------------------------------------
// tilt pid with fall guard
// pid velocity command with conditional integration and fall hysteresis
// ----------------------------------------------------------------------------
module tilt_pid_with_fall_guard import tpfg_pkg::*; (
  input logic         clk_i,
  input logic         rst_ni,
  tpfg_in_if.sink     in_i,
  tpfg_out_if.source  out_o,
  tpfg_cfg_if.sink    cfg_i
);

  cfg_t    cfg_q;
  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prop_gain         <= PROP_GAIN_RST;
      cfg_q.integ_gain        <= INTEG_GAIN_RST;
      cfg_q.deriv_gain        <= DERIV_GAIN_RST;
      cfg_q.trim_angle        <= TRIM_RST;
      cfg_q.output_limit      <= OUT_LIMIT_RST;
      cfg_q.fall_threshold    <= FALL_THR_RST;
      cfg_q.recover_threshold <= RECOVER_THR_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_PROP_GAIN:    cfg_q.prop_gain         <= cfg_i.data[GAIN_W-1:0];
        REG_INTEG_GAIN:   cfg_q.integ_gain        <= cfg_i.data[GAIN_W-1:0];
        REG_DERIV_GAIN:   cfg_q.deriv_gain        <= cfg_i.data[GAIN_W-1:0];
        REG_TRIM_ANGLE:   cfg_q.trim_angle        <= $signed(cfg_i.data[ANGLE_W-1:0]);
        REG_OUTPUT_LIMIT: cfg_q.output_limit      <= cfg_i.data[LIM_W-1:0];
        REG_FALL_THR:     cfg_q.fall_threshold    <= cfg_i.data[LIM_W-1:0];
        REG_RECOVER_THR:  cfg_q.recover_threshold <= cfg_i.data[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  tpfg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  tpfg_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .cmd_i    (cmd),
    .sts_o    (sts),
    .angle_i  (in_i.tilt_angle),
    .rate_i   (in_i.tilt_rate),
    .dt_i     (in_i.step_time_us),
    .left_o   (out_o.left_velocity),
    .right_o  (out_o.right_velocity),
    .fallen_o (out_o.is_fallen),
    .sat_o    (out_o.was_saturated)
  );

endmodule

FILE: rtl/tpfg_dp.sv
// ----------------------------------------------------------------------------
// tilt pid datapath
// shared multiplier, accumulators, fall flag, integral and result registers
// ----------------------------------------------------------------------------
`include "tilt_pid_with_fall_guard_defines.svh"

module tpfg_dp import tpfg_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cfg_t                      cfg_i,
  input  dp_cmd_t                   cmd_i,
  output dp_sts_t                   sts_o,
  input  logic signed [ANGLE_W-1:0] angle_i,
  input  logic signed [RATE_W-1:0]  rate_i,
  input  logic [DT_W-1:0]           dt_i,
  output logic signed [VEL_W-1:0]   left_o,
  output logic signed [VEL_W-1:0]   right_o,
  output logic                      fallen_o,
  output logic                      sat_o
);

  logic signed [ANGLE_W-1:0] angle_q;
  logic signed [RATE_W-1:0]  rate_q;
  logic [DT_W-1:0]           dt_q;
  logic                      fallen_q;
  logic signed [EI_W-1:0]    ei_q;
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [SUM_W-1:0]   pd_q;
  logic signed [SUM_W-1:0]   sum_q;
  logic [LIMF_W-1:0]         lim_q;
  logic signed [CL_W-1:0]    cl_q;
  logic [X_W-1:0]            x_q;
  logic                      neg_q;
  logic [Q_W-1:0]            qe_q;
  logic signed [VEL_W-1:0]   res_left_q;
  logic                      res_fallen_q;
  logic                      res_sat_q;
  logic signed [VEL_W-1:0]   out_left_q;
  logic signed [VEL_W-1:0]   out_right_q;
  logic                      out_fallen_q;
  logic                      out_sat_q;

  logic signed [ERR_W-1:0]    err;
  logic signed [ERR_W-1:0]    nrate;
  logic signed [ERR_W-1:0]    ang_ext;
  logic [ANGLE_W-1:0]         mag_ang;
  logic                       fall_enter;
  logic                       recovered;
  logic                       fall_next;
  logic                       skip;
  logic signed [MUL_A_W-1:0]  mul_a;
  logic [MUL_B_W-1:0]         mul_b;
  logic signed [PROD_W-1:0]   prod_d;
  logic signed [SUM_W-1:0]    prod_ext;
  logic signed [SUM_W-1:0]    lim_s;
  logic signed [SUM_W-1:0]    neg_lim;
  logic                       over_hi;
  logic                       over_lo;
  logic                       sat;
  logic signed [EI_SUM_W-1:0] ei_sum;
  logic signed [EI_SUM_W-1:0] ei_lim;
  logic signed [EI_W-1:0]     ei_clamped;
  logic signed [CL_W-1:0]     cl_d;
  logic [CL_W-1:0]            mag_cl;
  logic [CL_W-1:0]            rnd;
  logic signed [REM_W-1:0]    rem_w;
  logic signed [REM_W-1:0]    div_w;
  logic                       rem_ok;
  logic [Q_W-1:0]             q_fix;
  logic signed [VEL_W-1:0]    q_ext;
  logic signed [VEL_W-1:0]    left_d;

  // error, negated rate and fall tests
  assign err     = {cfg_i.trim_angle[ANGLE_W-1], cfg_i.trim_angle}
                 - {angle_q[ANGLE_W-1], angle_q};
  assign nrate   = -{rate_q[RATE_W-1], rate_q};
  assign ang_ext = {angle_q[ANGLE_W-1], angle_q};

  always_comb begin
    if (angle_q[ANGLE_W-1]) begin
      mag_ang = ANGLE_W'(-ang_ext);
    end else begin
      mag_ang = ANGLE_W'(ang_ext);
    end
  end

  assign fall_enter = !fallen_q && (mag_ang > {1'b0, cfg_i.fall_threshold});
  assign recovered  = fallen_q && (mag_ang < {1'b0, cfg_i.recover_threshold});
  assign fall_next  = fall_enter || (fallen_q && !recovered);
  assign skip       = (dt_q == '0) || (dt_q > DT_MAX);

  // shared multiplier operand select
  always_comb begin
    unique case (cmd_i.step)
      STEP_MUL_ERR: begin
        mul_a = {{(MUL_A_W-ERR_W){err[ERR_W-1]}}, err};
        mul_b = MEGA;
      end
      STEP_MUL_P: begin
        mul_a = prod_q[MUL_A_W-1:0];
        mul_b = {{(MUL_B_W-GAIN_W){1'b0}}, cfg_i.prop_gain};
      end
      STEP_MUL_RATE: begin
        mul_a = {{(MUL_A_W-ERR_W){nrate[ERR_W-1]}}, nrate};
        mul_b = MEGA;
      end
      STEP_MUL_D: begin
        mul_a = prod_q[MUL_A_W-1:0];
        mul_b = {{(MUL_B_W-GAIN_W){1'b0}}, cfg_i.deriv_gain};
      end
      STEP_MUL_LIM: begin
        mul_a = $signed({{(MUL_A_W-LIM_W){1'b0}}, cfg_i.output_limit});
        mul_b = MEGA;
      end
      STEP_MUL_I, STEP_MUL_I2: begin
        mul_a = {{(MUL_A_W-EI_W){ei_q[EI_W-1]}}, ei_q};
        mul_b = {{(MUL_B_W-GAIN_W){1'b0}}, cfg_i.integ_gain};
      end
      STEP_MUL_DT: begin
        mul_a = {{(MUL_A_W-ERR_W){err[ERR_W-1]}}, err};
        mul_b = {{(MUL_B_W-DT_W){1'b0}}, dt_q};
      end
      STEP_MUL_REC: begin
        mul_a = $signed({{(MUL_A_W-X_W){1'b0}}, x_q});
        mul_b = RECIP;
      end
      STEP_MUL_BACK: begin
        mul_a = $signed({{(MUL_A_W-Q_W){1'b0}}, prod_q[RECIP_SHIFT+Q_W-1:RECIP_SHIFT]});
        mul_b = DIV;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_d   = mul_a * $signed({1'b0, mul_b});
  assign prod_ext = {prod_q[PROD_W-1], prod_q};

  // preview and final clamp against the full-scale limit
  assign lim_s   = $signed({{(SUM_W-LIMF_W){1'b0}}, lim_q});
  assign neg_lim = -lim_s;
  assign over_hi = sum_q > lim_s;
  assign over_lo = sum_q < neg_lim;
  assign sat     = over_hi || over_lo;

  always_comb begin
    if (over_hi) begin
      cl_d = lim_s[CL_W-1:0];
    end else if (over_lo) begin
      cl_d = neg_lim[CL_W-1:0];
    end else begin
      cl_d = sum_q[CL_W-1:0];
    end
  end

  // integral update with clamp
  assign ei_sum = {{(EI_SUM_W-EI_W){ei_q[EI_W-1]}}, ei_q}
                + {{(EI_SUM_W-MUL_A_W){prod_q[MUL_A_W-1]}}, prod_q[MUL_A_W-1:0]};
  assign ei_lim = {{(EI_SUM_W-EI_W){INTEG_LIM[EI_W-1]}}, INTEG_LIM};

  always_comb begin
    if (ei_sum > ei_lim) begin
      ei_clamped = INTEG_LIM;
    end else if (ei_sum < -ei_lim) begin
      ei_clamped = -INTEG_LIM;
    end else begin
      ei_clamped = ei_sum[EI_W-1:0];
    end
  end

  // magnitude, rounding and reciprocal correction
  always_comb begin
    if (cl_q[CL_W-1]) begin
      mag_cl = CL_W'(-cl_q);
    end else begin
      mag_cl = CL_W'(cl_q);
    end
  end

  assign rnd    = mag_cl + HALF;
  assign rem_w  = $signed({{(REM_W-X_W){1'b0}}, x_q}) - $signed(prod_q[REM_W-1:0]);
  assign div_w  = $signed({{(REM_W-MUL_B_W){1'b0}}, DIV});
  assign rem_ok = (rem_w >= 0) && (rem_w < (div_w <<< 1));
  assign q_fix  = qe_q + Q_W'(rem_w >= div_w);
  assign q_ext  = $signed({1'b0, q_fix});

  always_comb begin
    if (neg_q) begin
      left_d = -q_ext;
    end else begin
      left_d = q_ext;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fallen_q <= 1'b0;
      ei_q     <= '0;
    end else begin
      if (cmd_i.step == STEP_FALL && !skip) begin
        fallen_q <= fall_next;
        if (fall_enter) begin
          ei_q <= '0;
        end
      end else if (cmd_i.step == STEP_SAT && !sat) begin
        ei_q <= ei_clamped;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      angle_q <= angle_i;
      rate_q  <= rate_i;
      dt_q    <= dt_i;
    end
    prod_q <= prod_d;
    unique case (cmd_i.step)
      STEP_FALL: begin
        res_fallen_q <= fall_next;
        res_left_q   <= '0;
        res_sat_q    <= 1'b0;
      end
      STEP_MUL_RATE: pd_q <= prod_ext;
      STEP_MUL_LIM:  pd_q <= pd_q + (prod_ext <<< D_SHIFT);
      STEP_MUL_I:    lim_q <= {prod_q[LIMF_W-LIM_SHIFT-1:0], {LIM_SHIFT{1'b0}}};
      STEP_MUL_DT:   sum_q <= pd_q + prod_ext;
      STEP_SAT:      res_sat_q <= sat;
      STEP_SUM2:     sum_q <= pd_q + prod_ext;
      STEP_CLAMP:    cl_q <= cl_d;
      STEP_ABS: begin
        x_q   <= rnd[ROUND_SHIFT+X_W-1:ROUND_SHIFT];
        neg_q <= cl_q[CL_W-1];
      end
      STEP_MUL_BACK: qe_q <= prod_q[RECIP_SHIFT+Q_W-1:RECIP_SHIFT];
      STEP_FIX:      res_left_q <= left_d;
      default: ;
    endcase
    if (cmd_i.out_load) begin
      out_left_q   <= res_left_q;
      out_right_q  <= -res_left_q;
      out_fallen_q <= res_fallen_q;
      out_sat_q    <= res_sat_q;
    end
  end

  assign sts_o.skip      = skip;
  assign sts_o.fall_next = fall_next;
  assign sts_o.sat       = sat;

  assign left_o   = out_left_q;
  assign right_o  = out_right_q;
  assign fallen_o = out_fallen_q;
  assign sat_o    = out_sat_q;

  `TPFG_ASSERT(a_integ_bounded, (ei_q <= INTEG_LIM) && (ei_q >= -INTEG_LIM), "integral range")
  `TPFG_ASSERT(a_fallen_integ_clear, fallen_q |-> (ei_q == '0), "integral set while fallen")
  `TPFG_ASSERT(a_quot_fix_range, (cmd_i.step == STEP_FIX) |-> rem_ok, "quotient estimate off")

endmodule

FILE: rtl/tpfg_ctrl.sv
// ----------------------------------------------------------------------------
// tilt pid controller
// sequences the datapath steps and owns the input and output handshakes
// ----------------------------------------------------------------------------
`include "tilt_pid_with_fall_guard_defines.svh"

module tpfg_ctrl import tpfg_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output dp_cmd_t cmd_o,
  input  dp_sts_t sts_i
);

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_load;
  logic        out_blocked;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_FALL;
        end
      end
      S_FALL: begin
        priority if (sts_i.skip) begin
          state_d = S_IDLE;
        end else if (sts_i.fall_next) begin
          state_d = S_OUT;
        end else begin
          state_d = S_MUL_ERR;
        end
      end
      S_MUL_ERR:  state_d = S_MUL_P;
      S_MUL_P:    state_d = S_MUL_RATE;
      S_MUL_RATE: state_d = S_MUL_D;
      S_MUL_D:    state_d = S_MUL_LIM;
      S_MUL_LIM:  state_d = S_MUL_I;
      S_MUL_I:    state_d = S_MUL_DT;
      S_MUL_DT:   state_d = S_SAT;
      S_SAT: begin
        if (sts_i.sat) begin
          state_d = S_CLAMP;
        end else begin
          state_d = S_MUL_I2;
        end
      end
      S_MUL_I2:   state_d = S_SUM2;
      S_SUM2:     state_d = S_CLAMP;
      S_CLAMP:    state_d = S_ABS;
      S_ABS:      state_d = S_MUL_REC;
      S_MUL_REC:  state_d = S_MUL_BACK;
      S_MUL_BACK: state_d = S_FIX;
      S_FIX:      state_d = S_OUT;
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default:    state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o    = (state_q == S_IDLE);
    out_load      = (state_q == S_OUT) && (!out_valid_q || out_ready_i);
    cmd_o.capture = in_ready_o && in_valid_i;
    cmd_o.out_load = out_load;
    unique case (state_q)
      S_FALL:     cmd_o.step = STEP_FALL;
      S_MUL_ERR:  cmd_o.step = STEP_MUL_ERR;
      S_MUL_P:    cmd_o.step = STEP_MUL_P;
      S_MUL_RATE: cmd_o.step = STEP_MUL_RATE;
      S_MUL_D:    cmd_o.step = STEP_MUL_D;
      S_MUL_LIM:  cmd_o.step = STEP_MUL_LIM;
      S_MUL_I:    cmd_o.step = STEP_MUL_I;
      S_MUL_DT:   cmd_o.step = STEP_MUL_DT;
      S_SAT:      cmd_o.step = STEP_SAT;
      S_MUL_I2:   cmd_o.step = STEP_MUL_I2;
      S_SUM2:     cmd_o.step = STEP_SUM2;
      S_CLAMP:    cmd_o.step = STEP_CLAMP;
      S_ABS:      cmd_o.step = STEP_ABS;
      S_MUL_REC:  cmd_o.step = STEP_MUL_REC;
      S_MUL_BACK: cmd_o.step = STEP_MUL_BACK;
      S_FIX:      cmd_o.step = STEP_FIX;
      default:    cmd_o.step = STEP_IDLE;
    endcase
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_blocked = (state_q == S_OUT) && out_valid_q && !out_ready_i;

  `TPFG_ASSERT_NEXT(a_accept_starts, cmd_o.capture, state_q == S_FALL, "accepted transaction lost")
  `TPFG_ASSERT_NEXT(a_result_waits, out_blocked, state_q == S_OUT, "pending result dropped")
  `TPFG_ASSERT_NEXT(a_valid_holds, out_valid_q && !out_ready_i, out_valid_q, "valid dropped early")

endmodule

FILE: sim/tb_tilt_pid_with_fall_guard.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tilt pid with fall guard testbench
// sends tilt samples and register writes over the channel interfaces and
// keeps a bit-exact model of the pid, the anti-windup integral and the fall
// hysteresis; every wheel command is compared field by field under phases of
// sender idling and receiver stalls across several register settings
// ----------------------------------------------------------------------------
module tb_tilt_pid_with_fall_guard;
  import tpfg_pkg::*;

  localparam longint STEP_MAX_US     = 64'sd1000000;
  localparam longint INTEG_CLAMP     = 64'sd20480000000;
  localparam longint CMD_SCALE       = 64'sd4096000000;
  localparam longint P_GAIN_SCALE    = 64'sd1000000;
  localparam longint D_GAIN_SCALE    = 64'sd16000000;
  localparam int     DRAIN_CYCLES    = 24;
  localparam int     ITEMS_PER_PHASE = 125;
  localparam int     NUM_PHASES      = 10;

  typedef struct packed {
    logic signed [VEL_W-1:0] left_velocity;
    logic signed [VEL_W-1:0] right_velocity;
    logic                    is_fallen;
    logic                    was_saturated;
  } wheel_cmd_t;

  logic clk_i;
  logic rst_ni;

  tpfg_in_if  in_if ();
  tpfg_out_if out_if ();
  tpfg_cfg_if cfg_if ();

  tilt_pid_with_fall_guard u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  cfg_t       reg_shadow;
  logic       fallen_state;
  longint     integ_acc;
  wheel_cmd_t expected_cmds[$];
  wheel_cmd_t exp_cmd;
  int         error_count;
  int         send_idle_pct;
  int         recv_stall_pct;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("tb_tilt_pid_with_fall_guard: errors");
    $finish;
  end

  function automatic cfg_t default_cfg();
    cfg_t c;
    c.prop_gain         = PROP_GAIN_RST;
    c.integ_gain        = INTEG_GAIN_RST;
    c.deriv_gain        = DERIV_GAIN_RST;
    c.trim_angle        = TRIM_RST;
    c.output_limit      = OUT_LIMIT_RST;
    c.fall_threshold    = FALL_THR_RST;
    c.recover_threshold = RECOVER_THR_RST;
    return c;
  endfunction

  function automatic cfg_t random_cfg(input bit wide);
    cfg_t c;
    if (wide) begin
      c.prop_gain         = GAIN_W'($urandom);
      c.integ_gain        = GAIN_W'($urandom);
      c.deriv_gain        = GAIN_W'($urandom);
      c.trim_angle        = ANGLE_W'($urandom);
      c.output_limit      = LIM_W'($urandom);
      c.fall_threshold    = LIM_W'($urandom);
      c.recover_threshold = LIM_W'($urandom);
    end else begin
      c.prop_gain         = GAIN_W'($urandom_range(80000));
      c.integ_gain        = GAIN_W'($urandom_range(260000));
      c.deriv_gain        = GAIN_W'($urandom_range(8000));
      c.trim_angle        = ANGLE_W'(int'($urandom_range(1024)) - 512);
      c.output_limit      = LIM_W'($urandom_range(32767, 1000));
      c.fall_threshold    = LIM_W'($urandom_range(6000, 1000));
      c.recover_threshold = LIM_W'($urandom_range(int'(c.fall_threshold), 500));
    end
    return c;
  endfunction

  function automatic longint clamp_sym(input longint v, input longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // updates the fall flag and integral; returns 1 when the sample yields a command
  function automatic bit compute_wheel_cmd(input logic signed [ANGLE_W-1:0] angle,
                                           input logic signed [RATE_W-1:0] rate,
                                           input logic [DT_W-1:0] dt,
                                           output wheel_cmd_t cmd);
    longint mag_angle, err, p_part, d_part, lim_full, sum, mag, rounded;
    logic   sat;
    cmd = '0;
    if (dt == '0 || longint'(dt) > STEP_MAX_US) return 1'b0;
    mag_angle = (angle < 0) ? -longint'(angle) : longint'(angle);
    if (!fallen_state && mag_angle > longint'(reg_shadow.fall_threshold)) begin
      fallen_state = 1'b1;
      integ_acc    = 0;
    end else if (fallen_state && mag_angle < longint'(reg_shadow.recover_threshold)) begin
      fallen_state = 1'b0;
    end
    if (fallen_state) begin
      cmd.is_fallen = 1'b1;
      return 1'b1;
    end
    err      = longint'($signed(reg_shadow.trim_angle)) - longint'(angle);
    p_part   = longint'(reg_shadow.prop_gain) * err * P_GAIN_SCALE;
    d_part   = -longint'(reg_shadow.deriv_gain) * longint'(rate) * D_GAIN_SCALE;
    lim_full = longint'(reg_shadow.output_limit) * CMD_SCALE;
    sum      = p_part + longint'(reg_shadow.integ_gain) * integ_acc + d_part;
    sat      = (sum > lim_full) || (sum < -lim_full);
    if (!sat) begin
      integ_acc = clamp_sym(integ_acc + err * longint'(dt), INTEG_CLAMP);
      sum       = p_part + longint'(reg_shadow.integ_gain) * integ_acc + d_part;
    end
    sum     = clamp_sym(sum, lim_full);
    mag     = (sum < 0) ? -sum : sum;
    rounded = (mag + CMD_SCALE / 2) / CMD_SCALE;
    if (sum < 0) rounded = -rounded;
    cmd.left_velocity  = VEL_W'(rounded);
    cmd.right_velocity = VEL_W'(-rounded);
    cmd.was_saturated  = sat;
    return 1'b1;
  endfunction

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk_i); while (cfg_if.ready !== 1'b1);
    case (idx)
      REG_PROP_GAIN:    reg_shadow.prop_gain = value;
      REG_INTEG_GAIN:   reg_shadow.integ_gain = value;
      REG_DERIV_GAIN:   reg_shadow.deriv_gain = value;
      REG_TRIM_ANGLE:   reg_shadow.trim_angle = value[ANGLE_W-1:0];
      REG_OUTPUT_LIMIT: reg_shadow.output_limit = value[LIM_W-1:0];
      REG_FALL_THR:     reg_shadow.fall_threshold = value[LIM_W-1:0];
      REG_RECOVER_THR:  reg_shadow.recover_threshold = value[LIM_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  // unused upper data bits carry noise, the block keeps only the field width
  task automatic apply_config(input cfg_t c);
    write_reg(REG_PROP_GAIN, c.prop_gain);
    write_reg(REG_INTEG_GAIN, c.integ_gain);
    write_reg(REG_DERIV_GAIN, c.deriv_gain);
    write_reg(REG_TRIM_ANGLE, {4'($urandom), c.trim_angle});
    write_reg(REG_OUTPUT_LIMIT, {5'($urandom), c.output_limit});
    write_reg(REG_FALL_THR, {5'($urandom), c.fall_threshold});
    write_reg(REG_RECOVER_THR, {5'($urandom), c.recover_threshold});
    cfg_if.valid <= 1'b0;
  endtask

  task automatic send_sample(input logic signed [ANGLE_W-1:0] angle,
                             input logic signed [RATE_W-1:0] rate,
                             input logic [DT_W-1:0] dt);
    wheel_cmd_t cmd;
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.tilt_angle   <= angle;
    in_if.tilt_rate    <= rate;
    in_if.step_time_us <= dt;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    if (compute_wheel_cmd(angle, rate, dt, cmd)) expected_cmds.push_back(cmd);
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (expected_cmds.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic send_random_sample(output bit counted);
    int               a, r, base, sel;
    logic [DT_W-1:0] dt;
    sel = $urandom_range(99);
    if (sel < 70) begin
      a = int'($urandom_range(2 * int'(reg_shadow.fall_threshold))) -
          int'(reg_shadow.fall_threshold);
    end else if (sel < 82) begin
      base = ($urandom_range(1)) ? int'(reg_shadow.fall_threshold) :
                                   int'(reg_shadow.recover_threshold);
      a = base + int'($urandom_range(4)) - 2;
      if ($urandom_range(1)) a = -a;
    end else begin
      a = int'($urandom);
    end
    r = ($urandom_range(99) < 60) ? int'($urandom_range(1024)) - 512 : int'($urandom);
    sel = $urandom_range(99);
    if (sel < 45) dt = DT_W'($urandom_range(20000, 1));
    else if (sel < 80) dt = DT_W'($urandom_range(1000000, 1));
    else if (sel < 90) dt = DT_W'(STEP_MAX_US);
    else if (sel < 94) dt = '0;
    else dt = DT_W'($urandom_range(1048575, 1000001));
    counted = (dt != '0) && (longint'(dt) <= STEP_MAX_US);
    send_sample(ANGLE_W'(a), RATE_W'(r), dt);
  endtask

  task automatic test_skip_and_extremes();
    send_sample(16'sd0, 16'sd0, 20'd1);
    send_sample(16'sd100, -16'sd100, 20'd1000000);
    send_sample(16'sd0, 16'sd0, 20'd0);
    send_sample(16'sd0, 16'sd0, 20'd1000001);
    send_sample(16'sd0, 16'sd0, 20'hFFFFF);
    send_sample(-16'sd500, 16'sh7FFF, 20'd5000);
    send_sample(16'sd500, 16'sh8000, 20'd5000);
  endtask

  task automatic test_fall_hysteresis();
    send_sample(16'sh7FFF, 16'sd0, 20'd1000);
    send_sample(16'sh8000, 16'sd0, 20'd1000);
    send_sample(16'sd2500, 16'sd0, 20'd1000);
    send_sample(16'sd0, 16'sd0, 20'd1000);
    send_sample(16'sd2867, 16'sd0, 20'd1000);
    send_sample(-16'sd2868, 16'sd0, 20'd1000);
    send_sample(-16'sd2007, 16'sd0, 20'd1000);
    send_sample(-16'sd2006, 16'sd0, 20'd1000);
  endtask

  task automatic test_saturation_and_trim();
    cfg_t c;
    repeat (2) send_sample(16'sd2000, 16'sd0, 20'd1000000);
    wait_idle();
    c = default_cfg();
    c.trim_angle = 16'sh7FFF;
    apply_config(c);
    send_sample(16'sd0, 16'sd0, 20'd1000);
    wait_idle();
    c.trim_angle = 16'sh8000;
    apply_config(c);
    send_sample(16'sd0, 16'sd0, 20'd1000);
  endtask

  task automatic test_zero_limit_and_swapped_thresholds();
    cfg_t c;
    wait_idle();
    c = default_cfg();
    c.output_limit = '0;
    apply_config(c);
    send_sample(16'sd0, 16'sd0, 20'd1000);
    send_sample(16'sd100, 16'sd0, 20'd1000);
    wait_idle();
    c = default_cfg();
    c.fall_threshold    = 15'd1000;
    c.recover_threshold = 15'd3000;
    apply_config(c);
    send_sample(16'sd1500, 16'sd0, 20'd1000);
    send_sample(16'sd2000, 16'sd0, 20'd1000);
    send_sample(16'sd1500, 16'sd0, 20'd1000);
  endtask

  task automatic test_random_phases();
    cfg_t c;
    int   sent;
    bit   counted;
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_idle();
      case (ph)
        0, 9: c = default_cfg();
        1, 7: c = random_cfg(1'b0);
        2, 6: c = random_cfg(1'b1);
        3: begin
          c = '1;
          c.trim_angle = 16'sh7FFF;
        end
        4: begin
          c = '0;
          c.trim_angle = 16'sh8000;
        end
        5: begin
          c = random_cfg(1'b0);
          c.recover_threshold = c.fall_threshold + LIM_W'($urandom_range(3000, 1));
        end
        default: begin
          c = random_cfg(1'b0);
          c.output_limit = '0;
        end
      endcase
      apply_config(c);
      case (ph % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 63;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 63;
        end
        default: begin
          send_idle_pct  = 17;
          recv_stall_pct = 17;
        end
      endcase
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        send_random_sample(counted);
        if (counted) sent++;
      end
    end
  endtask

  always @(negedge clk_i) begin
    out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (expected_cmds.size() == 0) begin
        $error("command transaction with none expected: left_velocity %0d",
               out_if.left_velocity);
        error_count++;
      end else begin
        exp_cmd = expected_cmds.pop_front();
        if (out_if.left_velocity !== exp_cmd.left_velocity) begin
          $error("left_velocity expected %0d actual %0d",
                 exp_cmd.left_velocity, out_if.left_velocity);
          error_count++;
        end
        if (out_if.right_velocity !== exp_cmd.right_velocity) begin
          $error("right_velocity expected %0d actual %0d",
                 exp_cmd.right_velocity, out_if.right_velocity);
          error_count++;
        end
        if (out_if.is_fallen !== exp_cmd.is_fallen) begin
          $error("is_fallen expected %0b actual %0b", exp_cmd.is_fallen, out_if.is_fallen);
          error_count++;
        end
        if (out_if.was_saturated !== exp_cmd.was_saturated) begin
          $error("was_saturated expected %0b actual %0b",
                 exp_cmd.was_saturated, out_if.was_saturated);
          error_count++;
        end
      end
    end
  end

  initial begin
    rst_ni             = 1'b0;
    in_if.valid        = 1'b0;
    in_if.tilt_angle   = '0;
    in_if.tilt_rate    = '0;
    in_if.step_time_us = '0;
    out_if.ready       = 1'b0;
    cfg_if.valid       = 1'b0;
    cfg_if.index       = '0;
    cfg_if.data        = '0;
    error_count        = 0;
    send_idle_pct      = 0;
    recv_stall_pct     = 0;
    reg_shadow         = default_cfg();
    fallen_state       = 1'b0;
    integ_acc          = 0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_skip_and_extremes();
    test_fall_hysteresis();
    test_saturation_and_trim();
    test_zero_limit_and_swapped_thresholds();
    test_random_phases();
    wait_idle();
    if (error_count == 0) begin
      $display("tb_tilt_pid_with_fall_guard: clean");
    end else begin
      $display("tb_tilt_pid_with_fall_guard: errors");
    end
    $finish;
  end

endmodule
